FILE: hdl/utf8_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// utf8_stream_decoder_defines
// assertion macros shared by the decoder rtl, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge out of reset
`define UTF8D_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("utf8d assertion failed");
// condition must never be true out of reset
`define UTF8D_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("utf8d forbidden condition seen");
`else
`define UTF8D_ASSERT(lbl, prop)
`define UTF8D_NEVER(lbl, cond)
`endif
`endif

FILE: hdl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// types and constants shared by the utf-8 stream decoder modules
// ----------------------------------------------------------------------------
`default_nettype none
package utf8d_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
	localparam logic [1:0]      CONT_TAG = 2'b10;

	// results caused by one input byte: some replacement characters,
	// then optionally one final result
	typedef struct packed {
		logic [1:0]      rep_cnt;
		logic            fin_vld;
		logic [CP_W-1:0] fin_cp;
		logic            fin_end;
	} burst_t;

endpackage
`default_nettype wire

FILE: hdl/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// input register, sequence state and per-byte decode into a result burst
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module utf8d_decode
	import utf8d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       free,
	output logic            burst_vld,
	output burst_t          burst
);

	typedef struct packed {
		logic            lead;
		logic [1:0]      br;
		logic [CP_W-1:0] acc;
		logic            fin_vld;
		logic [CP_W-1:0] fin_cp;
		logic            fin_end;
	} fresh_t;

	function automatic fresh_t fresh_decode(input logic [7:0] b);
		fresh_t f;
		f = '0;
		if (b == 8'h00) begin
			f.fin_vld = 1'b1;
			f.fin_end = 1'b1;
		end else if (!b[7]) begin
			f.fin_vld = 1'b1;
			f.fin_cp  = {{(CP_W-8){1'b0}}, b};
		end else if (b[7:5] == 3'b110) begin
			f.lead = 1'b1;
			f.br   = 2'd1;
			f.acc  = {{(CP_W-5){1'b0}}, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			f.lead = 1'b1;
			f.br   = 2'd2;
			f.acc  = {{(CP_W-4){1'b0}}, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			f.lead = 1'b1;
			f.br   = 2'd3;
			f.acc  = {{(CP_W-3){1'b0}}, b[2:0]};
		end else begin
			f.fin_vld = 1'b1;
			f.fin_cp  = REPL_CP;
		end
		return f;
	endfunction

	logic [7:0]      byte_s1;
	logic            vld_s1;
	logic [1:0]      br_q;
	logic [1:0]      ct_q;
	logic [CP_W-1:0] acc_q;
	logic [1:0]      br_n;
	logic [1:0]      ct_n;
	logic [CP_W-1:0] acc_n;
	logic [CP_W-1:0] acc_ext;
	fresh_t          fr;
	logic            take;

	assign take     = vld_s1 && free;
	assign in_ready = !vld_s1 || take;

	always_comb begin
		br_n    = br_q;
		ct_n    = ct_q;
		acc_n   = acc_q;
		burst   = '0;
		acc_ext = {acc_q[CP_W-7:0], byte_s1[5:0]};
		fr      = fresh_decode(byte_s1);
		if (br_q != 2'd0 && byte_s1[7:6] == CONT_TAG) begin
			acc_n = acc_ext;
			br_n  = br_q - 2'd1;
			ct_n  = ct_q + 2'd1;
			if (br_q == 2'd1) begin
				burst.fin_vld = 1'b1;
				burst.fin_cp  = acc_ext;
				ct_n          = 2'd0;
				acc_n         = '0;
			end
		end else begin
			// missing continuation: one replacement for the lead and one per taken byte
			if (br_q != 2'd0) begin
				burst.rep_cnt = (ct_q > 2'd2) ? 2'd3 : ct_q + 2'd1;
				br_n          = 2'd0;
				ct_n          = 2'd0;
				acc_n         = '0;
			end
			burst.fin_vld = fr.fin_vld;
			burst.fin_cp  = fr.fin_cp;
			burst.fin_end = fr.fin_end;
			if (fr.lead) begin
				br_n  = fr.br;
				ct_n  = 2'd0;
				acc_n = fr.acc;
			end
		end
		burst_vld = vld_s1 && (burst.rep_cnt != 2'd0 || burst.fin_vld);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			br_q   <= 2'd0;
			ct_q   <= 2'd0;
			acc_q  <= '0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (take) begin
				br_q  <= br_n;
				ct_q  <= ct_n;
				acc_q <= acc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	`UTF8D_NEVER(a_ct_bound, {1'b0, br_q} + {1'b0, ct_q} > 3'd3)
	`UTF8D_ASSERT(a_hold_stalled, (vld_s1 && !free) |=> (vld_s1 && $stable(byte_s1)))

endmodule
`default_nettype wire

FILE: hdl/utf8d_emit.sv
// ----------------------------------------------------------------------------
// utf8d_emit
// result register that plays out one burst, one result per transfer
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module utf8d_emit
	import utf8d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       burst_vld,
	input  burst_t          burst,
	output logic            free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [CP_W-1:0] code_point,
	output logic            end_of_text,
	output logic            last_result
);

	logic   busy_q;
	burst_t cur_q;
	logic   load;
	logic   xfer;

	assign xfer        = busy_q && out_ready;
	assign last_result = (cur_q.rep_cnt == 2'd0) || (cur_q.rep_cnt == 2'd1 && !cur_q.fin_vld);
	assign free        = !busy_q || (xfer && last_result);
	assign load        = burst_vld && free;

	assign out_valid   = busy_q;
	assign code_point  = (cur_q.rep_cnt != 2'd0) ? REPL_CP : cur_q.fin_cp;
	assign end_of_text = (cur_q.rep_cnt == 2'd0) && cur_q.fin_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (xfer && last_result) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= burst;
		end else if (xfer && cur_q.rep_cnt != 2'd0) begin
			cur_q.rep_cnt <= cur_q.rep_cnt - 2'd1;
		end
	end

	`UTF8D_ASSERT(a_end_is_last, (out_valid && end_of_text) |-> (last_result && code_point == '0))
	`UTF8D_ASSERT(a_busy_has_work, busy_q |-> (cur_q.rep_cnt != 2'd0 || cur_q.fin_vld))

endmodule
`default_nettype wire

FILE: hdl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// utf-8 byte stream to code point decoder, valid/ready on both sides
// ----------------------------------------------------------------------------
// Takes one byte per transfer and gives the decoded code points. A byte
// that causes no result (a lead byte, a non-final continuation byte) is
// taken once the result register has played out its last result; a
// byte that causes n results (one to four) occupies the output for n
// transfers, so the sustained input rate is one byte per cycle when every
// byte gives at most one result and the output is never stalled. The input
// register and the result register are separate, so a byte is taken while
// a result waits. A byte passes the input register and then the result
// register, which loads it only when free, before its first result is
// offered. Malformed input gives U+FFFD: a stray continuation, bytes
// F8-FF, and for a broken sequence one U+FFFD for the lead plus one per
// continuation already taken, after which the breaking byte is decoded
// afresh. A zero byte outside a sequence gives code point 0 with
// end_of_text set. No overlong or surrogate checks. last_result marks the
// final result of each byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module utf8_stream_decoder
	import utf8d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// byte input channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	// code point output channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [20:0]     code_point,
	output logic            end_of_text,
	output logic            last_result
);

	// burst descriptor from the decode stage and the emitter's take signal
	burst_t burst;
	logic   burst_vld;
	logic   free;

	// input register, sequence state, decode of one byte
	utf8d_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.free      (free),
		.burst_vld (burst_vld),
		.burst     (burst)
	);

	// result register, plays the burst out one transfer at a time
	utf8d_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_vld   (burst_vld),
		.burst       (burst),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.end_of_text (end_of_text),
		.last_result (last_result)
	);

	// an end marker is always the last result of its byte
	`UTF8D_ASSERT(a_top_end_last, (out_valid && end_of_text) |-> last_result)

endmodule
`default_nettype wire

FILE: tb/sv/utf8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// self-checking bench for the utf-8 stream decoder: a shadow decoder in the
// bench predicts every code point of each accepted byte, and a monitor on the
// output channel compares each transfer with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_tb
	import utf8d_pkg::*;
();

	// run control
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES  = 300;

	// lead byte prefixes
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	// one predicted output transfer
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            eot;
		logic            last;
	} cp_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic [20:0] code_point;
	logic        end_of_text;
	logic        last_result;

	// shadow decoder state
	logic [1:0]      pend_left;
	logic [1:0]      cont_seen;
	logic [CP_W-1:0] cp_acc;

	cp_result_t cp_want_q[$];
	cp_result_t cp_want;

	int unsigned cycle_cnt = 0;
	int unsigned fail_cnt  = 0;
	int unsigned bytes_sent = 0;
	bit          idle_en = 1'b1;
	bit          hold_req = 1'b0;

	utf8_stream_decoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.end_of_text (end_of_text),
		.last_result (last_result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// shadow decoder
	// ------------------------------------------------------------------

	function automatic void queue_cp(input logic [CP_W-1:0] cp, input logic eot);
		cp_result_t r;
		r.cp   = cp;
		r.eot  = eot;
		r.last = 1'b0;
		cp_want_q.push_back(r);
	endfunction

	// byte seen with no sequence pending
	function automatic void decode_fresh(input logic [7:0] b);
		if (b == 8'h00) begin
			queue_cp('0, 1'b1);
		end else if (!b[7]) begin
			queue_cp({13'b0, b}, 1'b0);
		end else if (b[7:5] == LEAD2_TAG) begin
			cp_acc    = {16'b0, b[4:0]};
			pend_left = 2'd1;
			cont_seen = 2'd0;
		end else if (b[7:4] == LEAD3_TAG) begin
			cp_acc    = {17'b0, b[3:0]};
			pend_left = 2'd2;
			cont_seen = 2'd0;
		end else if (b[7:3] == LEAD4_TAG) begin
			cp_acc    = {18'b0, b[2:0]};
			pend_left = 2'd3;
			cont_seen = 2'd0;
		end else begin
			// stray continuation or f8-ff
			queue_cp(REPL_CP, 1'b0);
		end
	endfunction

	// all code points one accepted byte produces; the final one gets last
	function automatic void decode_byte(input logic [7:0] b);
		int         first;
		cp_result_t r;
		first = cp_want_q.size();
		if (pend_left != 2'd0) begin
			if (b[7:6] == CONT_TAG) begin
				cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
				cont_seen = cont_seen + 2'd1;
				pend_left = pend_left - 2'd1;
				if (pend_left == 2'd0) begin
					queue_cp(cp_acc, 1'b0);
					cont_seen = 2'd0;
					cp_acc    = '0;
				end
			end else begin
				// broken sequence: one for the lead, one per continuation taken,
				// then the breaking byte is decoded as if nothing were pending
				queue_cp(REPL_CP, 1'b0);
				for (int i = 0; i < cont_seen && i < 2; i++)
					queue_cp(REPL_CP, 1'b0);
				pend_left = 2'd0;
				cont_seen = 2'd0;
				cp_acc    = '0;
				decode_fresh(b);
			end
		end else begin
			decode_fresh(b);
		end
		if (cp_want_q.size() > first) begin
			r = cp_want_q.pop_back();
			r.last = 1'b1;
			cp_want_q.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	// offers one byte, maybe after an idle burst, and returns at the edge of
	// its transfer; valid is left high so back-to-back bytes need no toggle
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			in_byte  <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [7:0] cont_byte();
		logic [5:0] bits;
		bits = 6'($urandom);
		return {CONT_TAG, bits};
	endfunction

	// a byte that breaks a pending sequence: anything but a continuation
	function automatic logic [7:0] break_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b[7:6] == CONT_TAG)
			b[6] = 1'b1;
		return b;
	endfunction

	// mostly well-formed characters with random payload, some noise and
	// truncated sequences
	task automatic send_random_char();
		int unsigned kind;
		int unsigned len;
		int unsigned taken;
		logic [7:0]  b;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			b = 8'($urandom_range(1, 127));
			if ($urandom_range(0, 19) == 0)
				b = 8'h00;
			send_byte(b);
		end else if (kind < 55) begin
			b = 8'($urandom);
			send_byte({LEAD2_TAG, b[4:0]});
			send_byte(cont_byte());
		end else if (kind < 70) begin
			b = 8'($urandom);
			send_byte({LEAD3_TAG, b[3:0]});
			repeat (2) send_byte(cont_byte());
		end else if (kind < 85) begin
			b = 8'($urandom);
			send_byte({LEAD4_TAG, b[2:0]});
			repeat (3) send_byte(cont_byte());
		end else if (kind < 92) begin
			send_byte(8'($urandom));
		end else begin
			len   = $urandom_range(2, 4);
			taken = $urandom_range(0, len - 2);
			b = 8'($urandom);
			case (len)
				2: begin
					send_byte({LEAD2_TAG, b[4:0]});
				end
				3: begin
					send_byte({LEAD3_TAG, b[3:0]});
				end
				default: begin
					send_byte({LEAD4_TAG, b[2:0]});
				end
			endcase
			repeat (taken) send_byte(cont_byte());
			send_byte(break_byte());
		end
	endtask

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------

	// ready with random stall bursts, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// every output transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (cp_want_q.size() == 0) begin
				$error("unexpected transfer: code_point %h", code_point);
				fail_cnt++;
			end else begin
				cp_want = cp_want_q.pop_front();
				if (code_point !== cp_want.cp) begin
					$error("code_point: expected %h, actual %h", cp_want.cp, code_point);
					fail_cnt++;
				end
				if (end_of_text !== cp_want.eot) begin
					$error("end_of_text: expected %b, actual %b", cp_want.eot, end_of_text);
					fail_cnt++;
				end
				if (last_result !== cp_want.last) begin
					$error("last_result: expected %b, actual %b", cp_want.last, last_result);
					fail_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// ascii extremes and the end marker
	task automatic test_ascii_edges();
		send_byte(8'h7F);
		send_byte(8'h00);
	endtask

	// shortest 2-byte, largest 3-byte and largest 4-byte values
	task automatic test_multibyte();
		send_byte(8'hC2);
		send_byte(8'h80);
		send_byte(8'hEF);
		send_byte(8'hBF);
		send_byte(8'hBF);
		send_byte(8'hF7);
		send_byte(8'hBF);
		send_byte(8'hBF);
		send_byte(8'hBF);
	endtask

	// stray bytes and each depth of broken sequence
	task automatic test_malformed();
		// stray continuation, invalid lead
		send_byte(8'h80);
		send_byte(8'hF8);
		// lead broken right away by ascii
		send_byte(8'hC3);
		send_byte(8'h41);
		// zero inside a sequence: replacements, then end marker
		send_byte(8'hE2);
		send_byte(8'h82);
		send_byte(8'h00);
		// broken by a new lead, which itself is broken by ff: ff gives four results
		send_byte(8'hF0);
		send_byte(8'h90);
		send_byte(8'h80);
		send_byte(8'hF0);
		send_byte(8'h90);
		send_byte(8'h80);
		send_byte(8'hFF);
	endtask

	task automatic test_random_text(input int unsigned n);
		int unsigned stop_at;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at)
			send_random_char();
	endtask

	// receiver holds off while bytes keep coming, so the input stalls
	task automatic test_backpressure();
		idle_en  = 1'b0;
		hold_req = 1'b1;
		repeat (40) send_byte(8'($urandom_range(1, 127)));
		while (hold_req) begin
			send_random_char();
		end
	endtask

	// last stretch at full rate on both sides
	task automatic test_full_rate();
		idle_en = 1'b0;
		test_random_text(60);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = 8'h00;
		pend_left = 2'd0;
		cont_seen = 2'd0;
		cp_acc    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii_edges();
		test_multibyte();
		test_malformed();
		test_random_text(220);
		test_backpressure();
		idle_en = 1'b1;
		test_random_text(20);
		test_full_rate();

		in_valid <= 1'b0;
		while (cp_want_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
